FILE: rtl/core/i2d_pkg.sv
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared constants and the binary-to-BCD step used by the decimal converter.
// ----------------------------------------------------------------------------
package i2d_pkg;

  localparam int NumDigits    = 19;
  localparam int BcdW         = 4 * NumDigits;
  localparam int ValueW       = 64;
  localparam int NumStages    = 8;
  localparam int BitsPerStage = ValueW / NumStages;
  localparam int IdxW         = 5;

  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharZero  = 8'd48;

  typedef logic [BcdW-1:0]   bcd_t;
  typedef logic [ValueW-1:0] value_t;

  // Shifts BitsPerStage binary bits, most significant first, into a BCD word.
  function automatic bcd_t dabble_chunk(input bcd_t bcd_in,
                                        input logic [BitsPerStage-1:0] bits);
    bcd_t b;
    b = bcd_in;
    for (int i = BitsPerStage - 1; i >= 0; i--) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      b = {b[BcdW-2:0], bits[i]};
    end
    return b;
  endfunction

endpackage

FILE: rtl/core/int64_to_decimal_ascii.sv
// A value passes the negate stage, the double-dabble stages and the serializer
// before its first beat. One character per cycle while out_ready is high;
// the serializer holds each value until all its 1 to 20 characters are out.
// The conversion pipeline is 1 negate stage plus 8 double-dabble stages.
// Reset (rst_n low, synchronous) empties every stage and the serializer.
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii
// Converts a signed 64-bit value to its decimal ASCII text, one character
// per output beat, with the final character flagged.
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii
  import i2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_character,
  output logic        out_last
);

  logic   vld_r [NumStages+1];
  value_t mag_r [NumStages+1];
  bcd_t   bcd_r [NumStages+1];
  logic   neg_r [NumStages+1];
  logic   rdy   [NumStages+2];
  bcd_t   bcd_nxt [NumStages+1];

  logic            ser_vld_r;
  logic            ser_sign_r;
  logic [IdxW-1:0] ser_idx_r;
  bcd_t            ser_bcd_r;
  logic            ser_ready;
  logic            ser_load;
  logic            out_fire;
  logic [IdxW-1:0] top_idx;
  logic [3:0]      digits [NumDigits];

  assign out_fire  = out_valid && out_ready;
  assign ser_ready = !ser_vld_r || (out_fire && out_last);
  assign ser_load  = ser_ready && vld_r[NumStages];
  assign in_ready  = rdy[0];

  always_comb begin
    rdy[NumStages+1] = ser_ready;
    for (int s = NumStages; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
  end

  always_comb begin
    bcd_nxt[0] = '0;
    for (int s = 1; s <= NumStages; s++) begin
      bcd_nxt[s] = dabble_chunk(bcd_r[s-1], mag_r[s-1][ValueW-1 -: BitsPerStage]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NumStages; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int s = 1; s <= NumStages; s++) begin
        if (rdy[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      neg_r[0] <= in_value[ValueW-1];
      mag_r[0] <= in_value[ValueW-1] ? (~in_value + 64'd1) : in_value;
      bcd_r[0] <= bcd_nxt[0];
    end
    for (int s = 1; s <= NumStages; s++) begin
      if (rdy[s]) begin
        neg_r[s] <= neg_r[s-1];
        mag_r[s] <= {mag_r[s-1][ValueW-BitsPerStage-1:0], {BitsPerStage{1'b0}}};
        bcd_r[s] <= bcd_nxt[s];
      end
    end
  end

  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd_r[NumStages][4*d +: 4] != 4'd0) begin
        top_idx = IdxW'(d);
      end
    end
  end

  always_comb begin
    for (int d = 0; d < NumDigits; d++) begin
      digits[d] = ser_bcd_r[4*d +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r  <= 1'b0;
      ser_sign_r <= 1'b0;
      ser_idx_r  <= '0;
    end else if (ser_load) begin
      ser_vld_r  <= 1'b1;
      ser_sign_r <= neg_r[NumStages];
      ser_idx_r  <= top_idx;
    end else if (out_fire) begin
      if (out_last) begin
        ser_vld_r <= 1'b0;
      end else if (ser_sign_r) begin
        ser_sign_r <= 1'b0;
      end else begin
        ser_idx_r <= ser_idx_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_bcd_r <= bcd_r[NumStages];
    end
  end

  assign out_valid     = ser_vld_r;
  assign out_character = ser_sign_r ? CharMinus : (CharZero + {4'd0, digits[ser_idx_r]});
  assign out_last      = !ser_sign_r && (ser_idx_r == '0);

endmodule

FILE: rtl/core/int64_to_decimal_ascii_checker.sv
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii_checker
// Port-level checks on the character stream of the decimal converter.
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii_checker
  import i2d_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [63:0] in_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_character,
  input logic        out_last
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_value))
    else $error("Input beat changed while stalled.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("Output beat changed while stalled.");

  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_character == CharMinus ||
                  (out_character >= CharZero && out_character <= CharZero + 8'd9))
    else $error("Output character is neither a sign nor a digit.");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_character == CharMinus |-> !out_last)
    else $error("Minus sign flagged as last character.");

  a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_character == CharMinus |=>
      out_valid && out_character != CharMinus && out_character != CharZero)
    else $error("Minus sign not followed by a nonzero leading digit.");

endmodule

bind int64_to_decimal_ascii int64_to_decimal_ascii_checker u_checker (.*);
